// ===== rtl/tdp_pkg.sv =====
// Package for the trial-division prime test.
// Holds the default datapath width and the number field width.
// No dependencies.
package tdp_pkg;

    localparam int WIDTH_DEFAULT = 32;
    localparam int NUMBER_BITS   = 31;

endpackage

// ===== rtl/trial_division_prime_test.sv =====
// Top level of the trial-division prime test.
// Depends on tdp_pkg for the default width and the number field width.
//
// Channel | Handshake                   | Payload
// --------+-----------------------------+-----------------------
// test    | test_valid / test_ready     | number[30:0]
// result  | result_valid / result_ready | is_prime
//
// Each trial divisor d, from 2 up while d*d <= n, passes through the square compare,
// the bit-serial restoring remainder unit over all NW = min(WIDTH-1, 31) bits of n
// and the zero test. Numbers 0 to 3 skip the division and are reported prime.
// test_ready is high only while no item is in work; reset clears all control state.
// A finished result waits in the output register until result_ready takes it.
module trial_division_prime_test #(
    parameter int WIDTH = tdp_pkg::WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          test_valid,
    output logic                          test_ready,
    input  logic [tdp_pkg::NUMBER_BITS-1:0] number,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          is_prime
);
    import tdp_pkg::*;

    localparam int NW = (WIDTH - 1 < NUMBER_BITS) ? WIDTH - 1 : NUMBER_BITS;
    localparam int DW = (NW + 1) / 2 + 1;
    localparam int SW = 2 * DW;
    localparam int CW = $clog2(NW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_TEST,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [DW-1:0]   d_reg, d_next;
    logic [SW-1:0]   sq_reg, sq_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            prime_reg, prime_next;
    logic            out_valid_reg, out_valid_next;
    logic            is_prime_reg, is_prime_next;

    logic [DW:0]     rem_shift;
    logic [DW+1:0]   rem_diff;
    logic [DW-1:0]   rem_step;

    // restoring remainder step: shift in one bit of n, subtract d if it fits
    always_comb
    begin
        rem_shift = {rem_reg, n_reg[cnt_reg]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, d_reg};
        if (rem_diff[DW+1])
        begin
            rem_step = rem_shift[DW-1:0];
        end
        else
        begin
            rem_step = rem_diff[DW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg && !result_ready;
        is_prime_next  = is_prime_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (test_valid)
                begin
                    n_next     = number[NW-1:0];
                    d_next     = DW'(2);
                    sq_next    = SW'(4);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sq_reg > SW'(n_reg))
                begin
                    prime_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = CW'(NW - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_step;
                if (cnt_reg == '0)
                begin
                    state_next = S_TEST;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_TEST:
            begin
                if (rem_reg == '0)
                begin
                    prime_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    // (d+1)^2 = d^2 + 2d + 1
                    sq_next    = sq_reg + SW'({d_reg, 1'b1});
                    d_next     = d_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = prime_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            d_reg         <= '0;
            sq_reg        <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            prime_reg     <= 1'b0;
            is_prime_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            d_reg         <= d_next;
            sq_reg        <= sq_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            prime_reg     <= prime_next;
            is_prime_reg  <= is_prime_next;
        end
    end

    assign test_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign is_prime     = is_prime_reg;

endmodule

// ===== rtl/tdp_checker.sv =====
// Port-level checker for the trial-division prime test, with its bind.
// Depends on tdp_pkg for the number field width.
module tdp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            test_valid,
    input logic                            test_ready,
    input logic [tdp_pkg::NUMBER_BITS-1:0] number,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic                            is_prime
);
    import tdp_pkg::*;

    logic test_xfer;
    logic number_seen;

    assign test_xfer   = test_valid && test_ready;
    assign number_seen = ^number;

    // hold a waiting result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(is_prime))
        else $error("result dropped or changed while stalled");

    // drop ready after a transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        test_xfer |=> !test_ready)
        else $error("test_ready high right after a transfer");

    // no result appears in the cycle after a transfer
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        test_xfer && (number_seen || !number_seen) |=> !$rose(result_valid))
        else $error("result appeared too early");

    // ready falls only on a transfer
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(test_ready) |-> $past(test_valid))
        else $error("test_ready fell without a transfer");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .test_valid   (test_valid),
    .test_ready   (test_ready),
    .number       (number),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_prime     (is_prime)
);
